FILE: hw/rtl/sliding_dft_phasor_estimator_core_macros.svh
// assertion macros shared by the phasor estimator rtl
`ifndef SLIDING_DFT_PHASOR_ESTIMATOR_CORE_MACROS_SVH
`define SLIDING_DFT_PHASOR_ESTIMATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, held off while reset is asserted
`define SDFT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define SDFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SDFT_ASSERT(lbl, clk, rstn, prop, msg)
`define SDFT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/sdft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdft_pkg;

  localparam int WINDOW_LEN_DEF   = 40;
  localparam int DECIMATION_DEF   = 2;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int NUM_TAPS   = 4;
  localparam int TAP_IDX_W  = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int ACC_W      = 34;
  localparam int FILT_W     = 18;
  localparam int DIFF_W     = 19;
  localparam int TW_W       = 17;
  localparam int PROD_W     = DIFF_W + TW_W;
  localparam int MAG_W      = 16;
  localparam int ANG_W      = 15;
  localparam int CNT_W      = 5;
  localparam int ZW         = 35;
  localparam int ATAN_W     = 32;
  localparam int MAG_SPLIT  = 21;
  localparam int ANG_SHIFT  = 23;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TAP0 = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TAP1 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TAP2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TAP3 = 2'd3;

  localparam logic signed [COEF_W-1:0] TAP0_RST = 16'sd0;
  localparam logic signed [COEF_W-1:0] TAP1_RST = 16'sd20025;
  localparam logic signed [COEF_W-1:0] TAP2_RST = 16'sd12743;
  localparam logic signed [COEF_W-1:0] TAP3_RST = 16'sd0;

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  // 23040 = 45 * 512, the 512 folds into the final shift
  localparam logic [5:0]  ANG_SCALE    = 6'd45;

  // angles in 2^-32 turn
  localparam logic signed [ZW-1:0] Z_QUARTER = 35'sh040000000;
  localparam logic signed [ZW-1:0] Z_HALF    = 35'sh080000000;
  localparam logic signed [ZW-1:0] Z_FULL    = 35'sh100000000;

  function automatic logic [ATAN_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic             load_in;
    logic             mac;
    logic             filt;
    logic             rot_step;
    logic             twid_fin;
    logic             mul_re;
    logic             mul_im;
    logic             commit;
    logic             vec_init;
    logic             vec_step;
    logic             mag_a;
    logic             mag_b;
    logic             div_step;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } sdft_cmd_t;

  typedef struct packed {
    logic keep;
    logic out_free;
  } sdft_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sdft_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sdft_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 40,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sdft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_dft_phasor_estimator_core_macros.svh"

module sdft_ctrl #(
  parameter int CORDIC_STEPS = sdft_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sdft_pkg::sdft_sts_t sts,
  output sdft_pkg::sdft_cmd_t cmd
);

  import sdft_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAC  = 4'd1;
  localparam logic [3:0] S_FILT = 4'd2;
  localparam logic [3:0] S_ROT  = 4'd3;
  localparam logic [3:0] S_TWF  = 4'd4;
  localparam logic [3:0] S_MRE  = 4'd5;
  localparam logic [3:0] S_MIM  = 4'd6;
  localparam logic [3:0] S_CMT  = 4'd7;
  localparam logic [3:0] S_VIN  = 4'd8;
  localparam logic [3:0] S_VEC  = 4'd9;
  localparam logic [3:0] S_MAGA = 4'd10;
  localparam logic [3:0] S_MAGB = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic [CNT_W-1:0] MAC_LAST  = CNT_W'(NUM_TAPS - 1);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(CORDIC_STEPS - 1);
  // reciprocal estimate, then one correction
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(1);

  logic [3:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = '0;
    cmd     = '0;
    cmd.cnt = cnt_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          st_nxt      = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (cnt_r == MAC_LAST) st_nxt = S_FILT;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_FILT: begin
        cmd.filt = 1'b1;
        st_nxt   = sts.keep ? S_ROT : S_IDLE;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        if (cnt_r == STEP_LAST) st_nxt = S_TWF;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_TWF: begin
        cmd.twid_fin = 1'b1;
        st_nxt       = S_MRE;
      end
      S_MRE: begin
        cmd.mul_re = 1'b1;
        st_nxt     = S_MIM;
      end
      S_MIM: begin
        cmd.mul_im = 1'b1;
        st_nxt     = S_CMT;
      end
      S_CMT: begin
        cmd.commit = 1'b1;
        st_nxt     = S_VIN;
      end
      S_VIN: begin
        cmd.vec_init = 1'b1;
        st_nxt       = S_VEC;
      end
      S_VEC: begin
        cmd.vec_step = 1'b1;
        if (cnt_r == STEP_LAST) st_nxt = S_MAGA;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_MAGA: begin
        cmd.mag_a = 1'b1;
        st_nxt    = S_MAGB;
      end
      S_MAGB: begin
        cmd.mag_b = 1'b1;
        st_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) st_nxt = S_OUT;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign in_tready = rst_n && (st_r == S_IDLE);

  `SDFT_ASSERT(a_accept_starts_mac, clk, rst_n, (st_r == S_IDLE && in_tvalid) |=> (st_r == S_MAC), "accepted sample did not start the filter")
  `SDFT_ASSERT(a_load_needs_room, clk, rst_n, cmd.out_load |-> sts.out_free, "result loaded over a waiting result")
  `SDFT_ASSERT(a_out_wait_holds, clk, rst_n, (st_r == S_OUT && !sts.out_free) |=> (st_r == S_OUT), "result dropped while output stalled")

endmodule

`default_nettype wire

FILE: hw/rtl/sdft_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_dft_phasor_estimator_core_macros.svh"

module sdft_dp #(
  parameter int WINDOW_LEN = sdft_pkg::WINDOW_LEN_DEF,
  parameter int DECIMATION = sdft_pkg::DECIMATION_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sdft_pkg::sdft_cmd_t                 cmd,
  output sdft_pkg::sdft_sts_t                 sts,
  input  logic [sdft_pkg::SAMPLE_W-1:0]       sample,
  input  logic                                cfg_we,
  input  logic [sdft_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sdft_pkg::COEF_W-1:0]         cfg_wdata,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [sdft_pkg::MAG_W-1:0]          out_magnitude,
  output logic [sdft_pkg::ANG_W-1:0]          out_angle,
  output logic                                out_window_full
);

  import sdft_pkg::*;

  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int PH_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int SUM_W  = 34 + $clog2(WINDOW_LEN);
  localparam int CW     = SUM_W + 2;
  localparam int TW2    = CW + 17;
  localparam int UW     = TW2 - 30;
  localparam int PR_W   = IDX_W + 1;
  localparam int MH_W   = CW - MAG_SPLIT + 16;

  localparam logic [32:0]       TURN        = 33'h1_0000_0000;
  localparam logic [31:0]       PH_STEP     = 32'(TURN / WINDOW_LEN);
  localparam logic [PR_W-1:0]   PH_STEP_REM = PR_W'(TURN % WINDOW_LEN);
  localparam logic [PR_W-1:0]   PH_REM_INIT = PR_W'(WINDOW_LEN / 2);
  localparam logic [PR_W-1:0]   N_REM       = PR_W'(WINDOW_LEN);
  localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(WINDOW_LEN - 1);
  localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(WINDOW_LEN);
  localparam logic [PH_W-1:0]   DPH_LAST    = PH_W'(DECIMATION - 1);
  localparam logic [TW2-1:0]    MAG_BIAS    = TW2'(WINDOW_LEN) << 29;
  localparam logic [UW-1:0]     SAT_LIM     = UW'(WINDOW_LEN) << MAG_W;
  // floor(2^32 / N), same value as the twiddle phase step
  localparam logic [31:0]       N_RECIP     = PH_STEP;
  localparam logic [UW-1:0]     N_U         = UW'(WINDOW_LEN);

  localparam logic signed [FILT_W-1:0] FILT_MAX = 18'sh1FFFF;
  localparam logic signed [FILT_W-1:0] FILT_MIN = 18'sh20000;

  // configuration and fir
  logic signed [COEF_W-1:0]   tap_r [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] dly_r [NUM_TAPS-1];
  logic signed [SAMPLE_W-1:0] x_in_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [FILT_W-1:0]   y_r;
  logic [PH_W-1:0]            dph_r;

  // window bookkeeping
  logic [IDX_W-1:0]  idx_r;
  logic [31:0]       ph_q_r;
  logic [PR_W-1:0]   ph_rem_r;
  logic [FILL_W-1:0] fill_r;

  // cordic and sums
  logic signed [CW-1:0]     cx_r, cy_r;
  logic signed [ZW-1:0]     cz_r;
  logic                     neg_r;
  logic                     zero_r;
  logic signed [TW_W-1:0]   c_r, s_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  re_r, im_r;

  // magnitude and angle
  logic [MH_W-1:0]      mph_r;
  logic [MAG_SPLIT-1:0] xl_r;
  logic [UW-1:0]        u_r;
  logic [MAG_W-1:0]     q_r;
  logic [ANG_W-1:0]     ang_r;

  logic [MAG_W-1:0] out_mag_r;
  logic [ANG_W-1:0] out_ang_r;
  logic             out_full_r;
  logic             out_valid_r;

  logic [FILT_W-1:0] ram_rdata;

  // combinational helpers
  logic signed [SAMPLE_W-1:0] mac_opd;
  logic signed [2*SAMPLE_W-1:0] mac_prod;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [DIFF_W-1:0]   y_full;
  logic signed [FILT_W-1:0]   y_sat;
  logic signed [ZW-1:0]       z_ph, z_fold;
  logic                       neg_fold;
  logic signed [CW-1:0]       dx, dy;
  logic signed [ZW-1:0]       at;
  logic                       sigma;
  logic signed [CW-1:0]       xs, ys, xr, yr;
  logic signed [FILT_W-1:0]   old_y;
  logic                       full;
  logic [PR_W-1:0]            rem_sum;
  logic signed [ZW-1:0]       z_wrap;
  logic signed [ZW+6:0]       ang_prod, ang_rnd;
  logic signed [CW-1:0]       xm;
  logic [TW2-1:0]             mag_t;
  logic [UW+31:0]             q_prod;
  logic [UW-1:0]              q_rem;
  logic                       q_inc;
  logic                       sat;

  always_comb begin
    case (cmd.cnt[TAP_IDX_W-1:0])
      2'd0:    mac_opd = x_in_r;
      2'd1:    mac_opd = dly_r[0];
      2'd2:    mac_opd = dly_r[1];
      default: mac_opd = dly_r[2];
    endcase
    mac_prod = tap_r[cmd.cnt[TAP_IDX_W-1:0]] * mac_opd;

    // round to q0 and clamp to 18 bits
    acc_rnd = acc_r + $signed(ACC_W'(16384));
    y_full  = acc_rnd[ACC_W-1:15];
    if (y_full[DIFF_W-1] != y_full[DIFF_W-2]) y_sat = y_full[DIFF_W-1] ? FILT_MIN : FILT_MAX;
    else y_sat = y_full[FILT_W-1:0];

    // twiddle phase folded into the right half plane
    z_ph     = ZW'($signed(ph_q_r));
    z_fold   = z_ph;
    neg_fold = 1'b0;
    if (z_ph > Z_QUARTER) begin
      z_fold   = z_ph - Z_HALF;
      neg_fold = 1'b1;
    end else if (z_ph < -Z_QUARTER) begin
      z_fold   = z_ph + Z_HALF;
      neg_fold = 1'b1;
    end

    // shared cordic step
    dx    = cy_r >>> cmd.cnt;
    dy    = cx_r >>> cmd.cnt;
    at    = $signed(ZW'(atan_turn(cmd.cnt)));
    sigma = cmd.rot_step ? !cz_r[ZW-1] : cy_r[CW-1];

    xs = neg_r ? -cx_r : cx_r;
    ys = neg_r ? -cy_r : cy_r;
    xr = xs + $signed(CW'(16384));
    yr = ys + $signed(CW'(16384));

    full  = (fill_r == FILL_FULL);
    old_y = full ? $signed(ram_rdata) : '0;

    rem_sum = ph_rem_r + PH_STEP_REM;

    z_wrap = cz_r;
    if (cz_r > Z_HALF) z_wrap = cz_r - Z_FULL;
    else if (cz_r <= -Z_HALF) z_wrap = cz_r + Z_FULL;
    ang_prod = (ZW + 7)'(z_wrap) * $signed({1'b0, ANG_SCALE});
    ang_rnd  = ang_prod + $signed((ZW + 7)'(1) << (ANG_SHIFT - 1));

    xm    = cx_r[CW-1] ? '0 : cx_r;
    mag_t = (TW2'(mph_r) << MAG_SPLIT) + TW2'(xl_r * INV_GAIN_Q16) + MAG_BIAS;

    // reciprocal estimate is low by at most one, one compare fixes it
    q_prod = (UW + 32)'(u_r) * (UW + 32)'(N_RECIP);
    q_rem  = u_r - UW'(q_r) * N_U;
    q_inc  = (q_rem >= N_U);

    sat = (u_r >= SAT_LIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r[0]    <= TAP0_RST;
      tap_r[1]    <= TAP1_RST;
      tap_r[2]    <= TAP2_RST;
      tap_r[3]    <= TAP3_RST;
      dly_r[0]    <= '0;
      dly_r[1]    <= '0;
      dly_r[2]    <= '0;
      dph_r       <= '0;
      idx_r       <= '0;
      ph_q_r      <= '0;
      ph_rem_r    <= PH_REM_INIT;
      fill_r      <= '0;
      re_r        <= '0;
      im_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TAP0: tap_r[0] <= $signed(cfg_wdata);
          REG_TAP1: tap_r[1] <= $signed(cfg_wdata);
          REG_TAP2: tap_r[2] <= $signed(cfg_wdata);
          REG_TAP3: tap_r[3] <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (cmd.filt) begin
        dly_r[2] <= dly_r[1];
        dly_r[1] <= dly_r[0];
        dly_r[0] <= x_in_r;
        dph_r    <= (dph_r == DPH_LAST) ? '0 : dph_r + PH_W'(1);
      end
      if (cmd.mul_im) begin
        re_r <= re_r + SUM_W'(prod_r);
      end
      if (cmd.commit) begin
        im_r <= im_r - SUM_W'(prod_r);
        if (fill_r != FILL_FULL) fill_r <= fill_r + FILL_W'(1);
        if (idx_r == IDX_LAST) begin
          idx_r    <= '0;
          ph_q_r   <= '0;
          ph_rem_r <= PH_REM_INIT;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
          if (rem_sum >= N_REM) begin
            ph_rem_r <= rem_sum - N_REM;
            ph_q_r   <= ph_q_r + PH_STEP + 32'd1;
          end else begin
            ph_rem_r <= rem_sum;
            ph_q_r   <= ph_q_r + PH_STEP;
          end
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in_r <= $signed(sample);
      acc_r  <= '0;
    end
    if (cmd.mac) acc_r <= acc_r + ACC_W'(mac_prod);
    if (cmd.filt) begin
      y_r   <= y_sat;
      cx_r  <= $signed(CW'(INV_GAIN_Q30));
      cy_r  <= '0;
      cz_r  <= z_fold;
      neg_r <= neg_fold;
    end
    if (cmd.rot_step || cmd.vec_step) begin
      if (sigma) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.twid_fin) begin
      c_r    <= xr[15 +: TW_W];
      s_r    <= yr[15 +: TW_W];
      diff_r <= DIFF_W'(y_r) - DIFF_W'(old_y);
    end
    if (cmd.mul_re) prod_r <= diff_r * c_r;
    if (cmd.mul_im) prod_r <= diff_r * s_r;
    if (cmd.vec_init) begin
      zero_r <= (re_r == '0) && (im_r == '0);
      if (re_r[SUM_W-1]) begin
        cx_r <= -CW'(re_r);
        cy_r <= -CW'(im_r);
        cz_r <= Z_HALF;
      end else begin
        cx_r <= CW'(re_r);
        cy_r <= CW'(im_r);
        cz_r <= '0;
      end
    end
    if (cmd.mag_a) begin
      ang_r <= ang_rnd[ANG_SHIFT +: ANG_W];
      mph_r <= MH_W'(xm[CW-1:MAG_SPLIT] * INV_GAIN_Q16);
      xl_r  <= xm[MAG_SPLIT-1:0];
    end
    if (cmd.mag_b) begin
      u_r <= mag_t[TW2-1:30];
      q_r <= '0;
    end
    if (cmd.div_step) begin
      if (cmd.cnt[0]) begin
        if (q_inc) q_r <= q_r + MAG_W'(1);
      end else begin
        q_r <= q_prod[32 +: MAG_W];
      end
    end
    if (cmd.out_load) begin
      out_mag_r  <= zero_r ? '0 : (sat ? '1 : q_r);
      out_ang_r  <= zero_r ? '0 : ang_r;
      out_full_r <= full;
    end
  end

  sdft_ram #(
    .WIDTH (FILT_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk     (clk),
    .we      (cmd.commit),
    .waddr   (idx_r),
    .wdata   (y_r),
    .re      (cmd.filt),
    .raddr   (idx_r),
    .rd_data (ram_rdata)
  );

  assign sts.keep        = (dph_r == '0);
  assign sts.out_free    = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_magnitude   = out_mag_r;
  assign out_angle       = out_ang_r;
  assign out_window_full = out_full_r;

  `SDFT_ASSERT(a_idx_steps, clk, rst_n, (cmd.commit && idx_r != IDX_LAST) |=> (idx_r == $past(idx_r) + IDX_W'(1)), "window slot did not advance")
  `SDFT_ASSERT(a_idx_wraps, clk, rst_n, (cmd.commit && idx_r == IDX_LAST) |=> (idx_r == '0 && ph_q_r == '0), "slot and twiddle phase out of step at wrap")

endmodule

`default_nettype wire

FILE: hw/rtl/sliding_dft_phasor_estimator_core.sv
// sliding one-cycle dft phasor estimator
// in_*  : one raw signed 16-bit sample per transaction (tvalid/tready)
// out_* : one phasor per kept sample: magnitude, angle in 1/64 degree and
//         a window-full flag in tuser
// cfg_* : write-only port for the four q1.15 fir taps, index 0..3
// each sample runs a 4-tap fir on one multiplier, one tap after another; every
// DECIMATION-th filtered sample is kept
// a dropped sample frees the input once it is filtered; a kept one then runs
// through the shared iterative cordic (twiddle rotation, then vectoring); the
// magnitude divide by the window length is a reciprocal multiply plus one
// correction step
// the input is taken only while the sequencer is idle
// results sit in an output register: a new sample is accepted while a result
// waits, and a finished result waits in the sequencer until that register
// is free, so a stalled receiver holds off the next result and the input
// synchronous reset (rst_n low) clears the fir line, window fill count,
// sums and the twiddle index and restores the tap defaults; window slots not
// yet filled read as zero through the fill count, so no clearing pass is run
`timescale 1ns / 1ps
`default_nettype none

module sliding_dft_phasor_estimator_core #(
  parameter int WINDOW_LEN   = sdft_pkg::WINDOW_LEN_DEF,
  parameter int DECIMATION   = sdft_pkg::DECIMATION_DEF,
  parameter int CORDIC_STEPS = sdft_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] sample
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [15:0] magnitude, [30:16] angle
  output logic [0:0]                      out_tuser,  // [0] window_full
  // configuration
  input  logic                            cfg_we,
  input  logic [sdft_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sdft_pkg::COEF_W-1:0]     cfg_wdata
);

  import sdft_pkg::*;

  sdft_cmd_t        cmd;
  sdft_sts_t        sts;
  logic [MAG_W-1:0] magnitude;
  logic [ANG_W-1:0] angle;
  logic             window_full;

  // sequencer: one state per datapath step
  sdft_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // fir, window memory, sums, shared cordic, divider and output register
  sdft_dp #(
    .WINDOW_LEN (WINDOW_LEN),
    .DECIMATION (DECIMATION)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .sample          (in_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_magnitude   (magnitude),
    .out_angle       (angle),
    .out_window_full (window_full)
  );

  // pack the result, top bit is padding
  assign out_tdata = {1'b0, angle, magnitude};
  assign out_tuser = window_full;

endmodule

`default_nettype wire
